// ----- src/tif_pkg.sv -----
// Package for the telnet IAC filter: Telnet command codes and the
// result-load record passed from the parser to the output sequencer.
// No dependencies.
`timescale 1ns / 1ps

package tif_pkg;

    // Telnet command bytes
    localparam logic [7:0] TN_SE   = 8'hF0;
    localparam logic [7:0] TN_SB   = 8'hFA;
    localparam logic [7:0] TN_WILL = 8'hFB;
    localparam logic [7:0] TN_WONT = 8'hFC;
    localparam logic [7:0] TN_DO   = 8'hFD;
    localparam logic [7:0] TN_DONT = 8'hFE;
    localparam logic [7:0] TN_IAC  = 8'hFF;

    // Reply burst: IAC, verb, option
    localparam int unsigned REPLY_LEN = 3;
    localparam int unsigned BEAT_W    = $clog2(REPLY_LEN);

    // One decoded item handed to the output sequencer
    typedef struct packed {
        logic       reply;   // 1: three-byte reply to network, 0: one data byte
        logic [7:0] verb;    // reply verb (DONT or WONT)
        logic [7:0] data;    // data byte, or option byte of a reply
    } load_t;

endpackage

// ----- src/tif_out_seq.sv -----
// Output sequencer for the telnet IAC filter: holds one decoded item and
// plays it out as one data byte or a three-byte reply burst.
// Depends on tif_pkg.
`timescale 1ns / 1ps

module tif_out_seq (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load_valid,
    input  tif_pkg::load_t load,
    output logic          load_ok,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_byte,
    output logic          m_to_network,
    output logic          m_last
);
    import tif_pkg::*;

    localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(REPLY_LEN - 1);

    logic              valid_reg;
    logic [BEAT_W-1:0] beat_reg;
    load_t             item_reg;
    logic              last_beat;

    // Last beat: a data byte, or the option byte of a reply
    assign last_beat = !item_reg.reply || (beat_reg == LAST_BEAT);

    // A new item may load when empty or when the final beat leaves now
    assign load_ok = !valid_reg || (m_ready && last_beat);

    // Control: valid and beat counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            beat_reg  <= '0;
        end else if (load_ok) begin
            valid_reg <= load_valid;
            beat_reg  <= '0;
        end else if (m_ready) begin
            beat_reg  <= beat_reg + 1'b1;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (load_ok && load_valid) begin
            item_reg <= load;
        end
    end

    // Byte selection per beat
    always_comb begin
        m_out_byte = item_reg.data;
        if (item_reg.reply) begin
            case (beat_reg)
                BEAT_W'(0): m_out_byte = TN_IAC;
                BEAT_W'(1): m_out_byte = item_reg.verb;
                default:    m_out_byte = item_reg.data;
            endcase
        end
    end

    assign m_valid      = valid_reg;
    assign m_to_network = item_reg.reply;
    assign m_last       = last_beat;

endmodule

// ----- src/telnet_iac_filter_core.sv -----
// Top level of the telnet IAC filter: Telnet command parser, enable register
// and output sequencer.
// Depends on tif_pkg and tif_out_seq.
`timescale 1ns / 1ps

// Telnet IAC option-refusal filter. Each received network byte on s_rx_byte
// is parsed in the cycle it is accepted and its results are loaded into the
// output register. Plain bytes (and IAC IAC as one 0xFF) leave as one data
// item with m_to_network low; a WILL/WONT or DO/DONT option request leaves
// as a three-item reply (IAC DONT opt, or IAC WONT opt) with m_to_network
// high and m_last on the third item; other commands and subnegotiation are
// absorbed. One byte per cycle is accepted while data flows and m_ready is
// high; during a reply the input waits until the third reply item is taken.
// Bytes that give no result still wait until a new item may load.
// cfg_telnet_enable (reset 1) clear passes every byte straight through; it is
// to be written only while the block is idle; the block itself does not enforce this.

module telnet_iac_filter_core (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_telnet_enable,
    // received bytes
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    // result items
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_to_network,
    output logic       m_last
);
    import tif_pkg::*;

    typedef enum logic [2:0] {
        ST_DATA      = 3'd0,
        ST_IAC       = 3'd1,
        ST_OPT_DONT  = 3'd2,
        ST_OPT_WONT  = 3'd3,
        ST_SUB       = 3'd4,
        ST_SUB_IAC   = 3'd5
    } state_t;

    state_t state_reg, state_next;
    logic   enable_reg;
    logic   accept;
    logic   load_valid;
    logic   load_ok;
    load_t  load;

    assign cfg_ready = 1'b1;
    assign s_ready   = load_ok;
    assign accept    = s_valid && s_ready;

    // Parser decode: next state and result for the byte at the input
    always_comb begin
        state_next = state_reg;
        load_valid = 1'b0;
        load.reply = 1'b0;
        load.verb  = TN_DONT;
        load.data  = s_rx_byte;
        if (!enable_reg) begin
            load_valid = 1'b1;
        end else begin
            case (state_reg)
                ST_DATA: begin
                    if (s_rx_byte == TN_IAC) begin
                        state_next = ST_IAC;
                    end else begin
                        load_valid = 1'b1;
                    end
                end
                ST_IAC: begin
                    case (s_rx_byte) inside
                        TN_IAC: begin
                            state_next = ST_DATA;
                            load_valid = 1'b1;
                        end
                        TN_WILL, TN_WONT: state_next = ST_OPT_DONT;
                        TN_DO, TN_DONT:   state_next = ST_OPT_WONT;
                        TN_SB:            state_next = ST_SUB;
                        default:          state_next = ST_DATA;
                    endcase
                end
                ST_OPT_DONT: begin
                    state_next = ST_DATA;
                    load_valid = 1'b1;
                    load.reply = 1'b1;
                    load.verb  = TN_DONT;
                end
                ST_OPT_WONT: begin
                    state_next = ST_DATA;
                    load_valid = 1'b1;
                    load.reply = 1'b1;
                    load.verb  = TN_WONT;
                end
                ST_SUB: begin
                    if (s_rx_byte == TN_IAC) begin
                        state_next = ST_SUB_IAC;
                    end
                end
                ST_SUB_IAC: begin
                    // IAC IAC inside a subnegotiation stays here
                    if (s_rx_byte == TN_SE) begin
                        state_next = ST_DATA;
                    end else if (s_rx_byte != TN_IAC) begin
                        state_next = ST_SUB;
                    end
                end
                default: state_next = ST_DATA;
            endcase
        end
    end

    // Parser state and enable register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_DATA;
            enable_reg <= 1'b1;
        end else begin
            if (accept) begin
                state_reg <= state_next;
            end
            if (cfg_valid && cfg_ready) begin
                enable_reg <= cfg_telnet_enable;
            end
        end
    end

    tif_out_seq u_out_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load_valid   (accept && load_valid),
        .load         (load),
        .load_ok      (load_ok),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_to_network (m_to_network),
        .m_last       (m_last)
    );

`ifndef NO_ASSERTIONS
    // Input is taken while a result waits only when its final item leaves now
    a_accept_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_ready && m_valid) |-> (m_ready && m_last))
        else $error("input accepted while a result burst is still pending");

    // A reply burst, once started, keeps going to the network
    a_burst_intact: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_to_network && !m_last) |=> (m_valid && m_to_network))
        else $error("reply burst broken before its last item");

    // A reply opens with IAC
    a_reply_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && load_valid && load.reply) |=> (m_valid && m_to_network
            && m_out_byte == TN_IAC && !m_last))
        else $error("reply does not start with IAC");
`endif

endmodule

// ----- tb/sv/tif_tb_pkg.sv -----
// Scoreboard for the telnet IAC filter testbench: parser predictor and
// store of expected result items.
// Depends on tif_pkg for the Telnet command codes.
`timescale 1ns / 1ps

package tif_tb_pkg;

    import tif_pkg::*;

    // Parser states of the predictor
    typedef enum logic [2:0] {
        PS_DATA       = 3'd0,
        PS_IAC        = 3'd1,
        PS_OPT_DONT   = 3'd2,
        PS_OPT_WONT   = 3'd3,
        PS_SUBNEG     = 3'd4,
        PS_SUBNEG_IAC = 3'd5
    } parse_state_t;

    // One result item as seen on the m_ channel
    typedef struct packed {
        logic [7:0] out_byte;
        logic       to_network;
        logic       last;
    } tif_out_t;

    class iac_scoreboard;
        parse_state_t state;
        bit           filter_on;
        tif_out_t     expected_items[$];
        int           fail_count;
        int           items_taken;

        function new();
            state       = PS_DATA;
            filter_on   = 1'b1;
            fail_count  = 0;
            items_taken = 0;
        endfunction

        function void set_enable(bit v);
            filter_on = v;
        endfunction

        function int pending();
            return expected_items.size();
        endfunction

        function void push_out(logic [7:0] b, logic net, logic lst);
            tif_out_t r;
            r.out_byte   = b;
            r.to_network = net;
            r.last       = lst;
            expected_items.push_back(r);
        endfunction

        // Advance the parser on one accepted byte and queue its results
        function void take_rx_byte(logic [7:0] b);
            items_taken++;
            if (!filter_on) begin
                // pass-through: parser state is left alone
                push_out(b, 1'b0, 1'b1);
            end else begin
                case (state)
                    PS_DATA: begin
                        if (b == TN_IAC) state = PS_IAC;
                        else push_out(b, 1'b0, 1'b1);
                    end
                    PS_IAC: begin
                        if (b == TN_IAC) begin
                            state = PS_DATA;
                            push_out(TN_IAC, 1'b0, 1'b1);
                        end else if (b == TN_WILL || b == TN_WONT) begin
                            state = PS_OPT_DONT;
                        end else if (b == TN_DO || b == TN_DONT) begin
                            state = PS_OPT_WONT;
                        end else if (b == TN_SB) begin
                            state = PS_SUBNEG;
                        end else begin
                            state = PS_DATA;   // unknown command dropped
                        end
                    end
                    PS_OPT_DONT, PS_OPT_WONT: begin
                        push_out(TN_IAC, 1'b1, 1'b0);
                        push_out((state == PS_OPT_DONT) ? TN_DONT : TN_WONT, 1'b1, 1'b0);
                        push_out(b, 1'b1, 1'b1);
                        state = PS_DATA;
                    end
                    PS_SUBNEG: begin
                        if (b == TN_IAC) state = PS_SUBNEG_IAC;
                    end
                    PS_SUBNEG_IAC: begin
                        // IAC IAC inside subnegotiation stays here
                        if (b == TN_SE) state = PS_DATA;
                        else if (b != TN_IAC) state = PS_SUBNEG;
                    end
                    default: state = PS_DATA;
                endcase
            end
        endfunction

        function void report(string msg);
            fail_count++;
            if (fail_count <= 10) $display("mismatch: %s", msg);
        endfunction

        // Compare one accepted result item with the oldest expectation
        function void check_out_item(logic [7:0] b, logic net, logic lst);
            tif_out_t want;
            if (expected_items.size() == 0) begin
                report($sformatf("unexpected item byte=%02h net=%0b last=%0b",
                                 b, net, lst));
                return;
            end
            want = expected_items.pop_front();
            if (want.out_byte !== b || want.to_network !== net || want.last !== lst)
                report($sformatf({"expected byte=%02h net=%0b last=%0b, ",
                                  "got byte=%02h net=%0b last=%0b"},
                                 want.out_byte, want.to_network, want.last,
                                 b, net, lst));
        endfunction
    endclass

endpackage

// ----- tb/sv/tb_telnet_iac_filter_core.sv -----
// Testbench top for telnet_iac_filter_core: drives directed and random
// Telnet byte streams with random idling on both sides, checks every item.
// Depends on tif_pkg, tif_tb_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_telnet_iac_filter_core;

    import tif_pkg::*;
    import tif_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;

    // Opening directed stream, filter on
    localparam logic [7:0] OPENING [25] = '{
        8'h00, 8'h7F,
        TN_IAC, TN_IAC,
        TN_IAC, TN_WILL, 8'h01,
        TN_IAC, TN_WONT, 8'hFF,
        TN_IAC, TN_DO, 8'h00,
        TN_IAC, TN_DONT, 8'h18,
        TN_IAC, 8'hF1,
        TN_IAC, TN_SB, 8'h18, TN_IAC, TN_IAC, TN_IAC, TN_SE
    };

    logic       aclk              = 1'b0;
    logic       aresetn           = 1'b0;
    logic       cfg_valid         = 1'b0;
    logic       cfg_ready;
    logic       cfg_telnet_enable = 1'b1;
    logic       s_valid           = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte         = 8'h00;
    logic       m_valid;
    logic       m_ready           = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_to_network;
    logic       m_last;

    iac_scoreboard sb = new();
    bit            no_idle = 1'b0;
    int            idle_cycles = 0;

    telnet_iac_filter_core u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_telnet_enable(cfg_telnet_enable),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_to_network     (m_to_network),
        .m_last           (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: cycles with no item moving on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("telnet_iac_filter_core regression: fail");
            $finish;
        end
    end

    // Result sink with random stalls
    initial begin : result_sink
        int stall;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_out_item(m_out_byte, m_to_network, m_last);
            @(negedge aclk);
        end
    end

    // Send one item; entered and left at a falling edge
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sb.take_rx_byte(b);
        @(negedge aclk);
    endtask

    // Hold off the sender until every expected item has come out
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_enable(bit v);
        drain_results();
        cfg_valid         <= 1'b1;
        cfg_telnet_enable <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_enable(v);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One random Telnet fragment: mostly well formed, some noise
    task automatic send_random_sequence();
        int         kind;
        int         n;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            b = 8'($urandom_range(0, 254));
            send_byte(b);
        end else if (kind < 45) begin
            send_byte(TN_IAC);
            send_byte(TN_IAC);
        end else if (kind < 70) begin
            send_byte(TN_IAC);
            b = 8'($urandom_range(TN_WILL, TN_DONT));
            send_byte(b);
            b = 8'($urandom_range(0, 255));
            send_byte(b);
        end else if (kind < 80) begin
            // subnegotiation, sometimes left unterminated
            send_byte(TN_IAC);
            send_byte(TN_SB);
            n = $urandom_range(0, 5);
            repeat (n) begin
                b = 8'($urandom_range(0, 255));
                send_byte(b);
                if (b == TN_IAC) send_byte(TN_IAC);
            end
            if ($urandom_range(0, 7) != 0) begin
                send_byte(TN_IAC);
                send_byte(TN_SE);
            end
        end else if (kind < 87) begin
            send_byte(TN_IAC);
            b = 8'($urandom_range(0, 8'hF9));
            send_byte(b);
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                b = 8'($urandom_range(0, 255));
                send_byte(b);
            end
        end
    endtask

    // Send random fragments until about target input items are accepted
    task automatic run_random(int target);
        int start_cnt;
        start_cnt = sb.items_taken;
        while (sb.items_taken - start_cnt < target) begin
            if ($urandom_range(0, 7) == 0) no_idle = !no_idle;
            if ($urandom_range(0, 29) == 0) drain_results();
            send_random_sequence();
        end
    endtask

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed opening with the reset setting
        foreach (OPENING[i]) send_byte(OPENING[i]);
        run_random(60);

        // disable mid-command: parser holds its state across pass-through
        send_byte(TN_IAC);
        send_byte(TN_WILL);
        write_enable(1'b0);
        send_byte(TN_IAC);
        send_byte(TN_DO);
        send_byte(8'hFF);
        run_random(30);
        write_enable(1'b1);
        send_byte(8'h2A);

        run_random(80);
        write_enable(1'b0);
        run_random(10);

        drain_results();
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("telnet_iac_filter_core regression: pass");
        else
            $display("telnet_iac_filter_core regression: fail");
        $finish;
    end

endmodule
